@@ rtl/apng_pkg.sv @@
// Shared types, constants and helper functions for the APNG chunk stream framer.
package apng_pkg;

    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int STEP_W          = 6;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] TYPE_IHDR  = 32'h49484452;
    localparam logic [31:0] TYPE_ACTL  = 32'h6163544C;
    localparam logic [31:0] TYPE_FCTL  = 32'h6663544C;
    localparam logic [31:0] TYPE_IDAT  = 32'h49444154;
    localparam logic [31:0] TYPE_FDAT  = 32'h66644154;
    localparam logic [31:0] TYPE_IEND  = 32'h49454E44;

    localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};

    typedef enum logic [1:0] {
        OP_BEGIN_FILE  = 2'd0,
        OP_BEGIN_FRAME = 2'd1,
        OP_DATA_BYTE   = 2'd2,
        OP_END_FILE    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_FRAME_COUNT     = 3'd2,
        REG_DLY_NUMERATOR   = 3'd3,
        REG_DLY_DENOMINATOR = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        CMD_REJECT = 3'd0,
        CMD_FILE   = 3'd1,
        CMD_FRAME  = 3'd2,
        CMD_DATA   = 3'd3,
        CMD_END    = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        logic [30:0] image_width;
        logic [30:0] image_height;
        logic [30:0] frame_count;
        logic [15:0] dly_numerator;
        logic [15:0] dly_denominator;
    } cfg_t;

    // one classified request handed from front to back
    typedef struct packed {
        cmd_kind_t   kind;
        logic [30:0] length;
        logic [7:0]  data_byte;
        logic [31:0] seq;
        logic        first_frame;
        logic        last_data;
    } cmd_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'b0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    // big-endian byte k of a word
    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = w[31:24];
            2'd1:    r = w[23:16];
            2'd2:    r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

@@ rtl/apng_cmd_fifo.sv @@
// Small command queue between the classifier and the byte sequencer.
module apng_cmd_fifo #(
    parameter int DEPTH = apng_pkg::CMD_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  apng_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output apng_pkg::cmd_t head_cmd,
    output logic           head_valid
);
    import apng_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/apng_front.sv @@
// Request classifier: checks sequence rules and tracks frame bookkeeping.
module apng_front (
    input  logic           clk,
    input  logic           rst_n,
    input  apng_pkg::cfg_t cfg,
    input  logic           req_valid,
    input  logic           req_ready,
    input  logic [1:0]     req_op,
    input  logic [30:0]    req_length,
    input  logic [7:0]     req_byte,
    output apng_pkg::cmd_t cmd
);
    import apng_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BETWEEN,
        PH_DATA
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] seq_reg, seq_next;
    logic [30:0] frames_reg, frames_next;
    logic [30:0] remain_reg, remain_next;

    always_comb
    begin
        cmd.kind        = CMD_REJECT;
        cmd.length      = req_length;
        cmd.data_byte   = req_byte;
        cmd.seq         = seq_reg;
        cmd.first_frame = (frames_reg == '0);
        cmd.last_data   = (remain_reg <= 31'd1);
        phase_next      = phase_reg;
        seq_next        = seq_reg;
        frames_next     = frames_reg;
        remain_next     = remain_reg;
        unique case (op_t'(req_op))
            OP_BEGIN_FILE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    cmd.kind    = CMD_FILE;
                    seq_next    = '0;
                    frames_next = '0;
                    phase_next  = PH_BETWEEN;
                end
            end
            OP_BEGIN_FRAME:
            begin
                if (phase_reg == PH_BETWEEN && frames_reg < cfg.frame_count
                    && req_length != '0)
                begin
                    cmd.kind    = CMD_FRAME;
                    // fdAT takes a second sequence number
                    seq_next    = seq_reg + (cmd.first_frame ? 32'd1 : 32'd2);
                    frames_next = frames_reg + 1'b1;
                    remain_next = req_length;
                    phase_next  = PH_DATA;
                end
            end
            OP_DATA_BYTE:
            begin
                if (phase_reg == PH_DATA)
                begin
                    cmd.kind = CMD_DATA;
                    if (remain_reg != '0)
                    begin
                        remain_next = remain_reg - 1'b1;
                    end
                    if (cmd.last_data)
                    begin
                        phase_next = PH_BETWEEN;
                    end
                end
            end
            OP_END_FILE:
            begin
                if (phase_reg == PH_BETWEEN && frames_reg >= cfg.frame_count)
                begin
                    cmd.kind   = CMD_END;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                cmd.kind = CMD_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            seq_reg    <= '0;
            frames_reg <= '0;
            remain_reg <= '0;
        end
        else if (req_valid && req_ready)
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            frames_reg <= frames_next;
            remain_reg <= remain_next;
        end
    end

endmodule

@@ rtl/apng_back.sv @@
// Byte sequencer: expands each command into stream bytes with CRC-32 tails.
module apng_back (
    input  logic           clk,
    input  logic           rst_n,
    input  apng_pkg::cfg_t cfg,
    input  apng_pkg::cmd_t head_cmd,
    input  logic           head_valid,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic [0:0]     m_tuser
);
    import apng_pkg::*;

    logic [STEP_W-1:0] idx_reg;
    logic [31:0]       crc_reg;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_status_reg;

    logic [7:0]  st_byte;
    logic        st_crc_en, st_crc_start, st_tail, st_last, st_status;
    logic [1:0]  st_k;
    logic [31:0] w_width, w_height, w_frames, w_len, w_seq1, crc_base;
    logic [7:0]  emit_byte;
    logic        fire;

    assign w_width  = {1'b0, cfg.image_width};
    assign w_height = {1'b0, cfg.image_height};
    assign w_frames = {1'b0, cfg.frame_count};
    assign w_len    = head_cmd.first_frame ? {1'b0, head_cmd.length}
                                           : {1'b0, head_cmd.length} + 32'd4;
    assign w_seq1   = head_cmd.seq + 32'd1;

    // per-command byte script, indexed by idx_reg
    always_comb
    begin
        st_byte      = '0;
        st_crc_en    = 1'b0;
        st_crc_start = 1'b0;
        st_tail      = 1'b0;
        st_k         = '0;
        st_last      = 1'b0;
        st_status    = 1'b0;
        unique case (head_cmd.kind)
            CMD_FILE:
            begin
                if (idx_reg < 6'd8)
                begin
                    st_byte = PNG_SIG[idx_reg[2:0]];
                end
                else if (idx_reg < 6'd12)
                begin
                    st_byte = be_byte(32'd13, 2'(idx_reg - 6'd8));
                end
                else if (idx_reg < 6'd29)
                begin
                    st_crc_en    = 1'b1;
                    st_crc_start = (idx_reg == 6'd12);
                    if (idx_reg < 6'd16)
                    begin
                        st_byte = be_byte(TYPE_IHDR, 2'(idx_reg - 6'd12));
                    end
                    else if (idx_reg < 6'd20)
                    begin
                        st_byte = be_byte(w_width, 2'(idx_reg - 6'd16));
                    end
                    else if (idx_reg < 6'd24)
                    begin
                        st_byte = be_byte(w_height, 2'(idx_reg - 6'd20));
                    end
                    else if (idx_reg == 6'd24)
                    begin
                        st_byte = 8'd8;   // bit depth
                    end
                    else if (idx_reg == 6'd25)
                    begin
                        st_byte = 8'd2;   // color type RGB
                    end
                end
                else if (idx_reg < 6'd33)
                begin
                    st_tail = 1'b1;
                    st_k    = 2'(idx_reg - 6'd29);
                end
                else if (idx_reg < 6'd37)
                begin
                    st_byte = be_byte(32'd8, 2'(idx_reg - 6'd33));
                end
                else if (idx_reg < 6'd49)
                begin
                    st_crc_en    = 1'b1;
                    st_crc_start = (idx_reg == 6'd37);
                    if (idx_reg < 6'd41)
                    begin
                        st_byte = be_byte(TYPE_ACTL, 2'(idx_reg - 6'd37));
                    end
                    else if (idx_reg < 6'd45)
                    begin
                        st_byte = be_byte(w_frames, 2'(idx_reg - 6'd41));
                    end
                end
                else
                begin
                    st_tail = 1'b1;
                    st_k    = 2'(idx_reg - 6'd49);
                    st_last = (idx_reg == 6'd52);
                end
            end
            CMD_FRAME:
            begin
                if (idx_reg < 6'd4)
                begin
                    st_byte = be_byte(32'd26, 2'(idx_reg));
                end
                else if (idx_reg < 6'd34)
                begin
                    st_crc_en    = 1'b1;
                    st_crc_start = (idx_reg == 6'd4);
                    if (idx_reg < 6'd8)
                    begin
                        st_byte = be_byte(TYPE_FCTL, 2'(idx_reg - 6'd4));
                    end
                    else if (idx_reg < 6'd12)
                    begin
                        st_byte = be_byte(head_cmd.seq, 2'(idx_reg - 6'd8));
                    end
                    else if (idx_reg < 6'd16)
                    begin
                        st_byte = be_byte(w_width, 2'(idx_reg - 6'd12));
                    end
                    else if (idx_reg < 6'd20)
                    begin
                        st_byte = be_byte(w_height, 2'(idx_reg - 6'd16));
                    end
                    else if (idx_reg >= 6'd28 && idx_reg < 6'd32)
                    begin
                        st_byte = be_byte({cfg.dly_numerator, cfg.dly_denominator},
                                          2'(idx_reg - 6'd28));
                    end
                end
                else if (idx_reg < 6'd38)
                begin
                    st_tail = 1'b1;
                    st_k    = 2'(idx_reg - 6'd34);
                end
                else if (idx_reg < 6'd42)
                begin
                    st_byte = be_byte(w_len, 2'(idx_reg - 6'd38));
                end
                else if (idx_reg < 6'd46)
                begin
                    st_crc_en    = 1'b1;
                    st_crc_start = (idx_reg == 6'd42);
                    st_byte      = be_byte(head_cmd.first_frame ? TYPE_IDAT : TYPE_FDAT,
                                           2'(idx_reg - 6'd42));
                    st_last      = head_cmd.first_frame && (idx_reg == 6'd45);
                end
                else
                begin
                    st_crc_en = 1'b1;
                    st_byte   = be_byte(w_seq1, 2'(idx_reg - 6'd46));
                    st_last   = (idx_reg == 6'd49);
                end
            end
            CMD_DATA:
            begin
                if (idx_reg == '0)
                begin
                    st_crc_en = 1'b1;
                    st_byte   = head_cmd.data_byte;
                    st_last   = !head_cmd.last_data;
                end
                else
                begin
                    st_tail = 1'b1;
                    st_k    = 2'(idx_reg - 6'd1);
                    st_last = (idx_reg == 6'd4);
                end
            end
            CMD_END:
            begin
                if (idx_reg < 6'd4)
                begin
                    st_byte = '0;
                end
                else if (idx_reg < 6'd8)
                begin
                    st_crc_en    = 1'b1;
                    st_crc_start = (idx_reg == 6'd4);
                    st_byte      = be_byte(TYPE_IEND, 2'(idx_reg - 6'd4));
                end
                else
                begin
                    st_tail = 1'b1;
                    st_k    = 2'(idx_reg - 6'd8);
                    st_last = (idx_reg == 6'd11);
                end
            end
            default:
            begin
                st_status = 1'b1;
                st_last   = 1'b1;
            end
        endcase
    end

    assign crc_base  = st_crc_start ? 32'hFFFFFFFF : crc_reg;
    assign emit_byte = st_tail ? be_byte(~crc_reg, st_k) : st_byte;
    assign fire      = head_valid && (!out_valid_reg || m_tready);
    assign pop       = fire && st_last;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_last_reg;
    assign m_tuser[0] = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            crc_reg       <= 32'hFFFFFFFF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                idx_reg       <= st_last ? '0 : idx_reg + 1'b1;
                out_valid_reg <= 1'b1;
                if (st_crc_en)
                begin
                    crc_reg <= crc32_byte(crc_base, st_byte);
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_byte_reg   <= emit_byte;
            out_last_reg   <= st_last;
            out_status_reg <= st_status;
        end
    end

endmodule

@@ rtl/apng_chunk_stream_framer_top.sv @@
// Top level of the APNG chunk stream framer: config registers and block wiring.
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: operation; tdata: length, byte
//  m_       | out | m_tvalid/m_tready  | tdata: out_byte; tlast; tuser: status
//  cfg_     | in  | cfg_we             | cfg_index selects register, cfg_data
//
// Each request is classified combinationally and queued. While m_tready holds high,
// the sequencer emits one byte per cycle: begin file 53, begin frame 46 (first) or
// 50, data byte 1 (5 on the last byte of a frame), end file 12, rejected request 1.
// Unstalled, data bytes sustain one per cycle; byte-wise CRC-32 update sets that rate.
// Reset (rst_n, async low) empties the queue and output register, no clearing pass.
// s_tready drops only when the command queue is full.
module apng_chunk_stream_framer_top #(
    parameter int CMD_DEPTH = apng_pkg::CMD_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [30:0] data_length, [38:31] data_byte, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] status
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);
    import apng_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd, head_cmd;
    logic q_full, q_pop, q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= 31'd1;
            cfg_reg.image_height    <= 31'd1;
            cfg_reg.frame_count     <= 31'd1;
            cfg_reg.dly_numerator   <= '0;
            cfg_reg.dly_denominator <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_IMAGE_WIDTH:     cfg_reg.image_width     <= cfg_data;
                REG_IMAGE_HEIGHT:    cfg_reg.image_height    <= cfg_data;
                REG_FRAME_COUNT:     cfg_reg.frame_count     <= cfg_data;
                REG_DLY_NUMERATOR:   cfg_reg.dly_numerator   <= cfg_data[15:0];
                REG_DLY_DENOMINATOR: cfg_reg.dly_denominator <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    assign s_tready = !q_full;

    apng_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_op     (s_tuser),
        .req_length (s_tdata[30:0]),
        .req_byte   (s_tdata[38:31]),
        .cmd        (front_cmd)
    );

    apng_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_cmd   (head_cmd),
        .head_valid (q_valid)
    );

    apng_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_cmd   (head_cmd),
        .head_valid (q_valid),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

@@ tb/tb_top.sv @@
// Testbench for the APNG chunk stream framer: predicts and checks each request's bytes.
module tb_top;
    import apng_pkg::*;

    localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;
    localparam logic [30:0] MAX_LEN = 31'd2147483643;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BETWEEN = 2'd1,
        PH_DATA    = 2'd2
    } framer_phase_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       status;
    } stream_byte_t;

    // Scoreboard: mirrors the framer state and holds the bytes still to come
    class apng_byte_predictor;
        logic [30:0]   width;
        logic [30:0]   height;
        logic [30:0]   frames_total;
        logic [15:0]   dly_numerator;
        logic [15:0]   dly_denominator;
        logic [31:0]   crc;
        logic [31:0]   seq_num;
        logic [31:0]   frames_done;
        logic [31:0]   remaining;
        framer_phase_t phase;
        stream_byte_t  expected_bytes[$];
        int            errors;

        function new();
            width           = 31'd1;
            height          = 31'd1;
            frames_total    = 31'd1;
            dly_numerator   = 16'd0;
            dly_denominator = 16'd0;
            crc             = '1;
            seq_num         = '0;
            frames_done     = '0;
            remaining       = '0;
            phase           = PH_IDLE;
            errors          = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [30:0] val);
            case (idx)
                REG_IMAGE_WIDTH:     width           = val;
                REG_IMAGE_HEIGHT:    height          = val;
                REG_FRAME_COUNT:     frames_total    = val;
                REG_DLY_NUMERATOR:   dly_numerator   = val[15:0];
                REG_DLY_DENOMINATOR: dly_denominator = val[15:0];
                default:             ;
            endcase
        endfunction

        function void push(logic [7:0] b, bit in_crc);
            stream_byte_t e;
            int k;
            if (in_crc)
            begin
                crc = crc ^ {24'd0, b};
                for (k = 0; k < 8; k++)
                    crc = crc[0] ? ((crc >> 1) ^ 32'hEDB88320) : (crc >> 1);
            end
            e.out_byte = b;
            e.last     = 1'b0;
            e.status   = 1'b0;
            expected_bytes.push_back(e);
        endfunction

        function void push_word(logic [31:0] w, bit in_crc);
            push(w[31:24], in_crc);
            push(w[23:16], in_crc);
            push(w[15:8], in_crc);
            push(w[7:0], in_crc);
        endfunction

        // length, then the type, which restarts the CRC
        function void open_chunk(logic [31:0] len, logic [31:0] tag);
            push_word(len, 1'b0);
            crc = '1;
            push_word(tag, 1'b1);
        endfunction

        function void close_chunk();
            push_word(~crc, 1'b0);
        endfunction

        function void note_request(op_t op, logic [30:0] len, logic [7:0] b);
            stream_byte_t e;
            int i;
            if (op == OP_BEGIN_FILE && phase == PH_IDLE)
            begin
                seq_num     = '0;
                frames_done = '0;
                for (i = 0; i < 8; i++)
                    push(PNG_SIG[i], 1'b0);
                open_chunk(32'd13, TYPE_IHDR);
                push_word({1'b0, width}, 1'b1);
                push_word({1'b0, height}, 1'b1);
                push(8'd8, 1'b1);
                push(8'd2, 1'b1);
                push(8'd0, 1'b1);
                push(8'd0, 1'b1);
                push(8'd0, 1'b1);
                close_chunk();
                open_chunk(32'd8, TYPE_ACTL);
                push_word({1'b0, frames_total}, 1'b1);
                push_word(32'd0, 1'b1);
                close_chunk();
                phase = PH_BETWEEN;
            end
            else if (op == OP_BEGIN_FRAME && phase == PH_BETWEEN &&
                     frames_done < {1'b0, frames_total} && len != 0)
            begin
                open_chunk(32'd26, TYPE_FCTL);
                push_word(seq_num, 1'b1);
                seq_num++;
                push_word({1'b0, width}, 1'b1);
                push_word({1'b0, height}, 1'b1);
                push_word(32'd0, 1'b1);
                push_word(32'd0, 1'b1);
                push(dly_numerator[15:8], 1'b1);
                push(dly_numerator[7:0], 1'b1);
                push(dly_denominator[15:8], 1'b1);
                push(dly_denominator[7:0], 1'b1);
                push(8'd0, 1'b1);
                push(8'd0, 1'b1);
                close_chunk();
                if (frames_done == 0)
                begin
                    open_chunk({1'b0, len}, TYPE_IDAT);
                end
                else
                begin
                    open_chunk({1'b0, len} + 32'd4, TYPE_FDAT);
                    push_word(seq_num, 1'b1);
                    seq_num++;
                end
                frames_done++;
                remaining = {1'b0, len};
                phase     = PH_DATA;
            end
            else if (op == OP_DATA_BYTE && phase == PH_DATA)
            begin
                push(b, 1'b1);
                if (remaining != 0)
                    remaining--;
                if (remaining == 0)
                begin
                    close_chunk();
                    phase = PH_BETWEEN;
                end
            end
            else if (op == OP_END_FILE && phase == PH_BETWEEN &&
                     frames_done >= {1'b0, frames_total})
            begin
                open_chunk(32'd0, TYPE_IEND);
                close_chunk();
                phase = PH_IDLE;
            end
            else
            begin
                // out of sequence: one zero byte flagged, state untouched
                e.out_byte = 8'd0;
                e.last     = 1'b0;
                e.status   = 1'b1;
                expected_bytes.push_back(e);
            end
            e = expected_bytes.pop_back();
            e.last = 1'b1;
            expected_bytes.push_back(e);
        endfunction

        function void check_byte(logic [7:0] b, logic last, logic status);
            stream_byte_t e;
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: no result expected, actual 0x%02h", b);
                errors++;
            end
            else
            begin
                e = expected_bytes.pop_front();
                if (b !== e.out_byte)
                begin
                    $error("out_byte: expected 0x%02h, actual 0x%02h", e.out_byte, b);
                    errors++;
                end
                if (last !== e.last)
                begin
                    $error("last_of_run: expected %0b, actual %0b", e.last, last);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status: expected %0b, actual %0b", e.status, status);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data  = '0;

    apng_byte_predictor stream_pred = new();
    bit no_idle    = 1'b0;
    int stall_pct  = 20;
    int stall_left = 0;
    int sent       = 0;

    apng_chunk_stream_framer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver back-pressure in random bursts, started with probability stall_pct
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            stream_pred.check_byte(m_tdata, m_tlast, m_tuser[0]);
    end

    task automatic send_request(op_t op, logic [30:0] len, logic [7:0] b);
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, b, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        stream_pred.note_request(op, len, b);
        sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (stream_pred.expected_bytes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(logic [30:0] w, logic [30:0] h, logic [30:0] fc,
                                logic [30:0] dn, logic [30:0] dd);
        logic [30:0] vals[5];
        int i;
        vals = '{w, h, fc, dn, dd};
        for (i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            stream_pred.write_reg(reg_idx_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [30:0] pick_dim();
        case ($urandom_range(0, 3))
            0:       return 31'd1;
            1:       return MAX31;
            default: return 31'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
    endfunction

    function automatic logic [30:0] pick_delay();
        case ($urandom_range(0, 3))
            0:       return 31'd0;
            1:       return 31'hFFFF;
            default: return 31'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // occasional stray request; accepted begin frames keep short lengths
    task automatic maybe_noise();
        op_t op;
        logic [30:0] len;
        if ($urandom_range(0, 9) == 0)
        begin
            op  = op_t'($urandom_range(0, 3));
            len = 31'($urandom);
            if (op == OP_BEGIN_FRAME && stream_pred.phase == PH_BETWEEN)
                len = 31'($urandom_range(0, 8));
            send_request(op, len, 8'($urandom));
        end
    endtask

    task automatic send_file();
        int frames;
        int len;
        int f;
        int i;
        frames = (stream_pred.frames_total > 4) ? 3 : int'(stream_pred.frames_total);
        maybe_noise();
        send_request(OP_BEGIN_FILE, 31'($urandom), 8'($urandom));
        for (f = 0; f < frames; f++)
        begin
            maybe_noise();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
            send_request(OP_BEGIN_FRAME, 31'(len), 8'($urandom));
            for (i = 0; i < len; i++)
            begin
                maybe_noise();
                send_request(OP_DATA_BYTE, 31'($urandom), 8'($urandom));
            end
        end
        maybe_noise();
        send_request(OP_END_FILE, 31'($urandom), 8'($urandom));
        // finish any frame left open by stray requests
        while (stream_pred.phase == PH_DATA)
            send_request(OP_DATA_BYTE, 31'($urandom), 8'($urandom));
    endtask

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int files;
        int i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, out-of-sequence cases, one full file
        write_config(31'd1, 31'd1, 31'd1, 31'd0, 31'd0);
        send_request(OP_END_FILE, 31'd0, 8'd0);
        send_request(OP_DATA_BYTE, 31'd0, 8'hFF);
        send_request(OP_BEGIN_FRAME, 31'd5, 8'd0);
        send_request(OP_BEGIN_FILE, MAX31, 8'hFF);
        send_request(OP_BEGIN_FILE, 31'd0, 8'd0);
        send_request(OP_BEGIN_FRAME, 31'd0, 8'd0);
        send_request(OP_DATA_BYTE, 31'd0, 8'h00);
        send_request(OP_END_FILE, 31'd0, 8'd0);
        send_request(OP_BEGIN_FRAME, 31'd1, 8'd0);
        send_request(OP_BEGIN_FRAME, 31'd1, 8'd0);
        send_request(OP_END_FILE, 31'd0, 8'd0);
        send_request(OP_DATA_BYTE, MAX31, 8'hFF);
        send_request(OP_BEGIN_FRAME, 31'd1, 8'd0);
        send_request(OP_END_FILE, 31'd0, 8'd0);

        // widest registers, IDAT then fdAT
        wait_drained();
        write_config(MAX31, MAX31, 31'd2, 31'hFFFF, 31'hFFFF);
        send_request(OP_BEGIN_FILE, 31'd0, 8'd0);
        send_request(OP_BEGIN_FRAME, 31'd2, 8'd0);
        send_request(OP_DATA_BYTE, 31'd0, 8'h00);
        send_request(OP_DATA_BYTE, 31'd0, 8'hA5);
        send_request(OP_BEGIN_FRAME, 31'd1, 8'd0);
        send_request(OP_DATA_BYTE, 31'd0, 8'h5A);
        send_request(OP_END_FILE, 31'd0, 8'd0);

        // zero frame count: end file straight after begin file
        wait_drained();
        write_config(31'd1, MAX31, 31'd0, 31'd0, 31'hFFFF);
        send_request(OP_BEGIN_FILE, 31'd0, 8'd0);
        send_request(OP_END_FILE, 31'd0, 8'd0);

        // random phases, each with fresh settings and back-pressure level
        while (sent < 440)
        begin
            wait_drained();
            write_config(pick_dim(), pick_dim(),
                         ($urandom_range(0, 7) == 0) ? MAX31 : 31'($urandom_range(0, 3)),
                         pick_delay(), pick_delay());
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 35;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            files = $urandom_range(2, 5);
            for (i = 0; i < files; i++)
                send_file();
        end

        // closing part, no idling: a frame of length MAX31 - 4 left open
        no_idle = 1'b1;
        wait_drained();
        write_config(pick_dim(), pick_dim(), MAX31, pick_delay(), pick_delay());
        send_file();
        send_request(OP_BEGIN_FRAME, MAX_LEN, 8'd0);
        for (i = 0; i < 3; i++)
            send_request(OP_DATA_BYTE, 31'($urandom), 8'($urandom));
        send_request(OP_END_FILE, 31'd0, 8'd0);
        send_request(OP_BEGIN_FILE, 31'd0, 8'd0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (stream_pred.errors == 0 && stream_pred.expected_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/apng_pkg.sv
rtl/apng_cmd_fifo.sv
rtl/apng_front.sv
rtl/apng_back.sv
rtl/apng_chunk_stream_framer_top.sv
tb/tb_top.sv
